// ----- design/rfa_pkg.sv -----
// ----------------------------------------------------------------------------
// rfa_pkg
// Shared constants, codes and types for the rational fraction ALU.
// ----------------------------------------------------------------------------
package rfa_pkg;

    localparam int WORD_BITS  = 32;
    localparam int FIELD_BITS = 32;
    localparam int MAG_BITS   = 64;

    // Largest legal positive value and largest legal negative magnitude
    localparam logic [MAG_BITS-1:0] MAG_HI  = MAG_BITS'((64'd1 << (WORD_BITS - 1)) - 64'd1);
    localparam logic [MAG_BITS-1:0] MAG_NEG = MAG_BITS'(64'd1 << (WORD_BITS - 1));

    localparam logic [2:0] FUNC_ADD  = 3'd0;
    localparam logic [2:0] FUNC_SUB  = 3'd1;
    localparam logic [2:0] FUNC_NEG  = 3'd2;
    localparam logic [2:0] FUNC_INC  = 3'd3;
    localparam logic [2:0] FUNC_NORM = 3'd4;
    localparam logic [2:0] FUNC_LESS = 3'd5;
    localparam logic [2:0] FUNC_EQ   = 3'd6;
    // Unassigned code, behaves as normalize
    localparam logic [2:0] FUNC_SPARE = 3'd7;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_DEN = 2'd1;
    localparam logic [1:0] ST_ZERO_ZERO = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    typedef struct packed {
        logic                start;
        logic [MAG_BITS-1:0] dividend;
        logic [MAG_BITS-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                busy;
        logic                done;
        logic [MAG_BITS-1:0] quo;
        logic [MAG_BITS-1:0] rem;
    } div_rsp_t;

    // Keep the low WORD_BITS bits, sign-extended from bit WORD_BITS-1
    function automatic logic [FIELD_BITS-1:0] sext(input logic [FIELD_BITS-1:0] v);
        logic [FIELD_BITS-1:0] r;
        for (int i = 0; i < FIELD_BITS; i++)
        begin
            r[i] = (i < WORD_BITS) ? v[i] : v[WORD_BITS-1];
        end
        return r;
    endfunction

    function automatic logic [FIELD_BITS-1:0] mag32(input logic [FIELD_BITS-1:0] v);
        return v[FIELD_BITS-1] ? (~v + 1'b1) : v;
    endfunction

endpackage

// ----- design/rfa_div.sv -----
// ----------------------------------------------------------------------------
// rfa_div
// Restoring radix-2 divider, unsigned 64 by 64, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rfa_div (
    input  logic              clk,
    input  logic              rst_n,
    input  rfa_pkg::div_req_t req,
    output rfa_pkg::div_rsp_t rsp
);

    localparam int W  = rfa_pkg::MAG_BITS;
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  dvs_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W:0]    shifted;
    logic [W:0]    diff;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[W-1]};
        diff      = shifted - {1'b0, dvs_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (busy_reg)
        begin
            if (!diff[W])
            begin
                rem_next = diff[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (req.start)
        begin
            rem_next  = '0;
            quo_next  = req.dividend;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (!busy_reg && req.start)
        begin
            dvs_reg <= req.divisor;
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
    assign rsp.rem  = rem_reg;

endmodule

// ----- design/rational_fraction_alu.sv -----
// ----------------------------------------------------------------------------
// rational_fraction_alu
// Add, subtract, negate, increment, normalize and compare signed fractions.
// ----------------------------------------------------------------------------
// Input channel s_*: one item carries two fractions in s_tdata and the
// operation code in s_tuser. Output channel m_*: one result item per input.
// s_tready is high only while the sequencer is idle; an item is then worked
// on alone until its result is staged for the output register.
// Each operand, and then the result, is reduced by a Euclid GCD loop in which
// every remainder comes from the shared restoring divider, plus two more
// divisions by the GCD when it exceeds one. Latency is therefore data
// dependent. An item with a zero denominator goes from idle straight to the
// output state, skipping the reduction. Cross products use one 32x32
// multiplier in the states S_MUL1, S_MUL2 and S_MUL3.
// The output register holds its item until m_tready; the sequencer waits in
// its final state while the output register is full, and the next input is
// not taken before the result is staged.
// Reset clears the sequencer, the divider and m_tvalid.
// ----------------------------------------------------------------------------
module rational_fraction_alu (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,  // a_num, a_den, b_num, b_den
    input  logic [2:0]   s_tuser,  // func
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [71:0]  m_tdata   // res_num, res_den, cmp_true, unit_fraction, status
);

    localparam int MW = rfa_pkg::MAG_BITS;
    localparam int FW = rfa_pkg::FIELD_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_GCD, S_GWAIT, S_DIVN, S_DIVD, S_FIN, S_MUL1, S_MUL2, S_MUL3,
        S_COMB, S_CHECK, S_OUT
    } state_t;

    typedef enum logic [1:0] {
        TGT_A, TGT_B, TGT_R
    } tgt_t;

    state_t         state_reg;
    tgt_t           tgt_reg;
    logic [2:0]     func_reg;
    logic           uses_b;

    logic           an_s_reg, bn_s_reg;
    logic [MW-1:0]  an_mag_reg, ad_mag_reg, bn_mag_reg, bd_mag_reg;
    logic           wn_s_reg;
    logic [MW-1:0]  wn_mag_reg, wd_mag_reg, x_reg, y_reg, g_reg;
    logic [MW-1:0]  p1_reg, p2_reg, p3_reg;

    logic [FW-1:0]  res_num_reg;
    logic [30:0]    res_den_reg;
    logic           res_cmp_reg, res_unit_reg;
    logic [1:0]     res_st_reg;

    logic           m_tvalid_reg;
    logic [71:0]    m_tdata_reg;

    rfa_pkg::div_req_t div_req;
    rfa_pkg::div_rsp_t div_rsp;

    logic [FW-1:0]  in_an, in_ad, in_bn, in_bd;
    logic [FW-1:0]  mul_a, mul_b;
    logic [MW-1:0]  product;
    logic           sm_s;
    logic [MW-1:0]  sm_mag;
    logic           lt_q;

    // Signed-magnitude add; zero always comes out with a clear sign
    function automatic logic [MW:0] sm_add(input logic s1, input logic [MW-1:0] m1,
                                           input logic s2, input logic [MW-1:0] m2);
        logic [MW-1:0] m;
        logic          s;
        if (s1 == s2)
        begin
            m = m1 + m2;
            s = s1;
        end
        else if (m1 >= m2)
        begin
            m = m1 - m2;
            s = s1;
        end
        else
        begin
            m = m2 - m1;
            s = s2;
        end
        return {s && (m != '0), m};
    endfunction

    rfa_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (div_req),
        .rsp  (div_rsp)
    );

    assign in_an = rfa_pkg::sext(s_tdata[31:0]);
    assign in_ad = rfa_pkg::sext(s_tdata[63:32]);
    assign in_bn = rfa_pkg::sext(s_tdata[95:64]);
    assign in_bd = rfa_pkg::sext(s_tdata[127:96]);

    assign uses_b = (func_reg == rfa_pkg::FUNC_ADD) || (func_reg == rfa_pkg::FUNC_SUB) ||
                    (func_reg == rfa_pkg::FUNC_LESS) || (func_reg == rfa_pkg::FUNC_EQ);

    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = x_reg;
        div_req.divisor  = y_reg;
        case (state_reg)
            S_GCD:
            begin
                if (y_reg != '0)
                begin
                    div_req.start = 1'b1;
                end
                else if (x_reg > MW'(1))
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = wn_mag_reg;
                    div_req.divisor  = x_reg;
                end
            end
            S_DIVN:
            begin
                div_req.dividend = wd_mag_reg;
                div_req.divisor  = g_reg;
                div_req.start    = div_rsp.done;
            end
            default:
            begin
                div_req.start = 1'b0;
            end
        endcase
    end

    // Shared multiplier operands, selected by step
    always_comb
    begin
        case (state_reg)
            S_MUL1:
            begin
                mul_a = an_mag_reg[FW-1:0];
                mul_b = bd_mag_reg[FW-1:0];
            end
            S_MUL2:
            begin
                mul_a = ad_mag_reg[FW-1:0];
                mul_b = bn_mag_reg[FW-1:0];
            end
            default:
            begin
                mul_a = ad_mag_reg[FW-1:0];
                mul_b = bd_mag_reg[FW-1:0];
            end
        endcase
        product = MW'(mul_a) * MW'(mul_b);
    end

    always_comb
    begin
        logic s1, s2;
        {sm_s, sm_mag} = '0;
        case (func_reg)
            rfa_pkg::FUNC_ADD:
                {sm_s, sm_mag} = sm_add(an_s_reg, p1_reg, bn_s_reg, p2_reg);
            rfa_pkg::FUNC_SUB:
                {sm_s, sm_mag} = sm_add(an_s_reg, p1_reg, !bn_s_reg, p2_reg);
            rfa_pkg::FUNC_NEG:
                {sm_s, sm_mag} = {!an_s_reg && (an_mag_reg != '0), an_mag_reg};
            rfa_pkg::FUNC_INC:
                {sm_s, sm_mag} = sm_add(an_s_reg, an_mag_reg, 1'b0, ad_mag_reg);
            default:
                {sm_s, sm_mag} = {an_s_reg, an_mag_reg};
        endcase
        s1 = an_s_reg && (p1_reg != '0);
        s2 = bn_s_reg && (p2_reg != '0);
        if (s1 != s2)
        begin
            lt_q = s1;
        end
        else if (s1)
        begin
            lt_q = p1_reg > p2_reg;
        end
        else
        begin
            lt_q = p1_reg < p2_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            tgt_reg      <= TGT_A;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == S_OUT && (!m_tvalid_reg || m_tready))
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        func_reg   <= s_tuser;
                        bn_s_reg   <= (in_bn[FW-1] ^ in_bd[FW-1]) && (in_bn != '0);
                        bn_mag_reg <= MW'(rfa_pkg::mag32(in_bn));
                        bd_mag_reg <= MW'(rfa_pkg::mag32(in_bd));
                        wn_s_reg   <= (in_an[FW-1] ^ in_ad[FW-1]) && (in_an != '0);
                        wn_mag_reg <= MW'(rfa_pkg::mag32(in_an));
                        wd_mag_reg <= MW'(rfa_pkg::mag32(in_ad));
                        x_reg      <= MW'(rfa_pkg::mag32(in_an));
                        y_reg      <= MW'(rfa_pkg::mag32(in_ad));
                        tgt_reg    <= TGT_A;
                        res_num_reg  <= '0;
                        res_den_reg  <= '0;
                        res_cmp_reg  <= 1'b0;
                        res_unit_reg <= 1'b0;
                        res_st_reg   <= rfa_pkg::ST_OK;
                        if (in_ad == '0)
                        begin
                            res_st_reg <= (in_an == '0) ? rfa_pkg::ST_ZERO_ZERO
                                                        : rfa_pkg::ST_ZERO_DEN;
                            state_reg  <= S_OUT;
                        end
                        else if ((s_tuser == rfa_pkg::FUNC_ADD || s_tuser == rfa_pkg::FUNC_SUB ||
                                  s_tuser == rfa_pkg::FUNC_LESS || s_tuser == rfa_pkg::FUNC_EQ)
                                 && in_bd == '0)
                        begin
                            res_st_reg <= (in_bn == '0) ? rfa_pkg::ST_ZERO_ZERO
                                                        : rfa_pkg::ST_ZERO_DEN;
                            state_reg  <= S_OUT;
                        end
                        else
                        begin
                            state_reg <= S_GCD;
                        end
                    end
                end
                S_GCD:
                begin
                    if (y_reg != '0)
                    begin
                        state_reg <= S_GWAIT;
                    end
                    else if (x_reg > MW'(1))
                    begin
                        g_reg     <= x_reg;
                        state_reg <= S_DIVN;
                    end
                    else
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_GWAIT:
                begin
                    if (div_rsp.done)
                    begin
                        x_reg     <= y_reg;
                        y_reg     <= div_rsp.rem;
                        state_reg <= S_GCD;
                    end
                end
                S_DIVN:
                begin
                    if (div_rsp.done)
                    begin
                        wn_mag_reg <= div_rsp.quo;
                        state_reg  <= S_DIVD;
                    end
                end
                S_DIVD:
                begin
                    if (div_rsp.done)
                    begin
                        wd_mag_reg <= div_rsp.quo;
                        state_reg  <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    case (tgt_reg)
                        TGT_A:
                        begin
                            an_s_reg   <= wn_s_reg;
                            an_mag_reg <= wn_mag_reg;
                            ad_mag_reg <= wd_mag_reg;
                            if (uses_b)
                            begin
                                wn_s_reg   <= bn_s_reg;
                                wn_mag_reg <= bn_mag_reg;
                                wd_mag_reg <= bd_mag_reg;
                                x_reg      <= bn_mag_reg;
                                y_reg      <= bd_mag_reg;
                                tgt_reg    <= TGT_B;
                                state_reg  <= S_GCD;
                            end
                            else
                            begin
                                state_reg <= S_COMB;
                            end
                        end
                        TGT_B:
                        begin
                            bn_s_reg   <= wn_s_reg;
                            bn_mag_reg <= wn_mag_reg;
                            bd_mag_reg <= wd_mag_reg;
                            state_reg  <= (func_reg == rfa_pkg::FUNC_EQ) ? S_COMB : S_MUL1;
                        end
                        default:
                        begin
                            state_reg <= S_CHECK;
                        end
                    endcase
                end
                S_MUL1:
                begin
                    p1_reg    <= product;
                    state_reg <= S_MUL2;
                end
                S_MUL2:
                begin
                    p2_reg    <= product;
                    state_reg <= (func_reg == rfa_pkg::FUNC_LESS) ? S_COMB : S_MUL3;
                end
                S_MUL3:
                begin
                    p3_reg    <= product;
                    state_reg <= S_COMB;
                end
                S_COMB:
                begin
                    if (func_reg == rfa_pkg::FUNC_LESS || func_reg == rfa_pkg::FUNC_EQ)
                    begin
                        logic c;
                        if (func_reg == rfa_pkg::FUNC_LESS)
                        begin
                            c = lt_q;
                        end
                        else
                        begin
                            c = (an_s_reg == bn_s_reg) && (an_mag_reg == bn_mag_reg) &&
                                (ad_mag_reg == bd_mag_reg);
                        end
                        res_num_reg  <= FW'(c);
                        res_den_reg  <= 31'd1;
                        res_cmp_reg  <= c;
                        res_unit_reg <= c;
                        state_reg    <= S_OUT;
                    end
                    else
                    begin
                        wn_s_reg   <= sm_s;
                        wn_mag_reg <= sm_mag;
                        x_reg      <= sm_mag;
                        if (func_reg == rfa_pkg::FUNC_ADD || func_reg == rfa_pkg::FUNC_SUB)
                        begin
                            wd_mag_reg <= p3_reg;
                            y_reg      <= p3_reg;
                        end
                        else
                        begin
                            wd_mag_reg <= ad_mag_reg;
                            y_reg      <= ad_mag_reg;
                        end
                        tgt_reg   <= TGT_R;
                        state_reg <= S_GCD;
                    end
                end
                S_CHECK:
                begin
                    if ((wn_s_reg ? (wn_mag_reg > rfa_pkg::MAG_NEG)
                                  : (wn_mag_reg > rfa_pkg::MAG_HI)) ||
                        (wd_mag_reg > rfa_pkg::MAG_HI))
                    begin
                        res_st_reg <= rfa_pkg::ST_OVERFLOW;
                    end
                    else
                    begin
                        res_num_reg  <= wn_s_reg ? (~wn_mag_reg[FW-1:0] + 1'b1)
                                                 : wn_mag_reg[FW-1:0];
                        res_den_reg  <= wd_mag_reg[30:0];
                        res_unit_reg <= !wn_s_reg && (wn_mag_reg == MW'(1));
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_OUT && (!m_tvalid_reg || m_tready))
        begin
            m_tdata_reg <= {5'd0, res_st_reg, res_unit_reg, res_cmp_reg, res_den_reg,
                            res_num_reg};
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Divider must be quiet whenever a new item can enter
    a_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !div_rsp.busy)
        else $error("divider busy while idle");

    // Divider results only arrive in a state that consumes them
    a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_GWAIT || state_reg == S_DIVN ||
                          state_reg == S_DIVD))
        else $error("divider result dropped");

    // A failed item carries all-zero result fields
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[66:65] != rfa_pkg::ST_OK) |-> (m_tdata[64:0] == '0))
        else $error("nonzero result with error status");

    // Denominator of an ok result is never zero
    a_den_nz: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[66:65] == rfa_pkg::ST_OK) |-> (m_tdata[62:32] != '0))
        else $error("zero denominator on ok result");

endmodule
